FILE: hdl/rgb_to_hsv_conversion_defines.svh
// assertion macros for the rgb to hsv converter
`ifndef RGB_TO_HSV_CONVERSION_DEFINES_SVH
`define RGB_TO_HSV_CONVERSION_DEFINES_SVH

`ifndef SYNTH

// property checked on every rising clock edge outside reset
`define RHC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rgb_to_hsv_conversion: assertion failed");

// property that also covers the reset cycles
`define RHC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("rgb_to_hsv_conversion: reset assertion failed");

`else

`define RHC_ASSERT(label, prop)
`define RHC_ASSERT_RST(label, prop)

`endif

`endif

FILE: hdl/rhc_pkg.sv
// types and constants shared by the rgb to hsv converter
package rhc_pkg;

    // field widths of one beat on each side
    localparam int IN_BITS     = 8;
    localparam int HUE_BITS    = 15;
    localparam int SAT_BITS    = 9;
    localparam int BRIGHT_BITS = 8;

    // default width of one color component inside the block
    localparam int COMPONENT_BITS_DEF = 8;

    // hue quotient is at most 3840, saturation quotient at most 256
    localparam int HUE_Q_BITS = 12;

    // saturation is delta/max in q1.8
    localparam int SAT_FRAC = 8;

    // hue slope 3840 = 2^12 - 2^8
    localparam int HUE_SLOPE_HI = 12;
    localparam int HUE_SLOPE_LO = 8;

    // sector bases and full turn in 1/64 degree
    localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd7680;
    localparam logic [HUE_BITS-1:0] HUE_FULL   = 15'd23040;

    // which component holds the maximum
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } t_hue_sector;

    // input beat
    typedef struct packed {
        logic [IN_BITS-1:0] red;
        logic [IN_BITS-1:0] green;
        logic [IN_BITS-1:0] blue;
    } t_rgb_pixel;

    // output beat
    typedef struct packed {
        logic [HUE_BITS-1:0]    hue;
        logic [SAT_BITS-1:0]    saturation;
        logic [BRIGHT_BITS-1:0] brightness;
        logic                   hue_undefined;
    } t_hsv_pixel;

endpackage

FILE: hdl/rgb_to_hsv_conversion.sv
// Converts a stream of rgb pixels to hue, saturation and value. One pixel
// is taken per clock and one result leaves per clock while the receiver
// does not stall. The pipeline is set by the two restoring
// dividers (saturation delta/max and hue 3840*diff/delta) that run side by
// side over 12 stages, one quotient bit per stage, between an input register,
// a min/max stage, a numerator stage and an output register. Each stage holds
// its beat when the stage after it is full and stalled, so bubbles are squeezed
// out and input is stalled only when every stage holds a pixel.
`include "rgb_to_hsv_conversion_defines.svh"

module rgb_to_hsv_conversion #(
    parameter int COMPONENT_BITS = rhc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rhc_pkg::t_rgb_pixel i_rgb,
    output logic                o_valid,
    input  logic                i_stall,
    output rhc_pkg::t_hsv_pixel o_hsv
);

    localparam int W  = COMPONENT_BITS;
    localparam int IW = (W < rhc_pkg::IN_BITS) ? W : rhc_pkg::IN_BITS;
    localparam int EW = (W > rhc_pkg::BRIGHT_BITS) ? W : rhc_pkg::BRIGHT_BITS;
    localparam int DQ = rhc_pkg::HUE_Q_BITS;
    localparam int RW = W + DQ;
    localparam int NS = DQ + 4;

    // stage valid bits and load enables
    logic [NS-1:0] r_v;
    logic [NS:0]   ld;

    // stage 0: input register
    logic [W-1:0] r0_r, r0_g, r0_b;

    // stage 1: max, min, sector and hue difference
    logic [W-1:0]         r1_mx, r1_del, r1_mag;
    rhc_pkg::t_hue_sector r1_sec;
    logic                 r1_neg;
    logic [W-1:0]         n1_mx, n1_mn, n1_mag, n1_a, n1_b;
    rhc_pkg::t_hue_sector n1_sec;
    logic                 n1_neg;

    // divider stages: index 0 holds the numerators, index DQ the quotients
    logic [RW-1:0]        r_hrem [DQ+1];
    logic [RW-1:0]        r_srem [DQ+1];
    logic [DQ-1:0]        r_hq   [DQ+1];
    logic [DQ-1:0]        r_sq   [DQ+1];
    logic [W-1:0]         r_dmx  [DQ+1];
    logic [W-1:0]         r_ddel [DQ+1];
    rhc_pkg::t_hue_sector r_dsec [DQ+1];
    logic                 r_dneg [DQ+1];

    // output stage
    rhc_pkg::t_hsv_pixel r_out;
    rhc_pkg::t_hsv_pixel n_out;

    // load chain: a stage loads when empty or when the next one loads
    assign ld[NS] = !i_stall;
    for (genvar s = 0; s < NS; s++) begin : g_ld
        assign ld[s] = !r_v[s] || ld[s+1];
    end

    assign o_stall = !ld[0];
    assign o_valid = r_v[NS-1];
    assign o_hsv   = r_out;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (ld[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage 0: components taken in their low bits
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r0_r <= W'(i_rgb.red[IW-1:0]);
            r0_g <= W'(i_rgb.green[IW-1:0]);
            r0_b <= W'(i_rgb.blue[IW-1:0]);
        end
    end

    // stage 1: max with red over green over blue on ties, min, diff sign
    always_comb begin
        n1_mx  = r0_r;
        n1_sec = rhc_pkg::SECT_RED;
        if (r0_g > n1_mx) begin
            n1_mx  = r0_g;
            n1_sec = rhc_pkg::SECT_GREEN;
        end
        if (r0_b > n1_mx) begin
            n1_mx  = r0_b;
            n1_sec = rhc_pkg::SECT_BLUE;
        end
        n1_mn = r0_r;
        if (r0_g < n1_mn) begin
            n1_mn = r0_g;
        end
        if (r0_b < n1_mn) begin
            n1_mn = r0_b;
        end
        case (n1_sec)
            rhc_pkg::SECT_RED: begin
                n1_a = r0_g;
                n1_b = r0_b;
            end
            rhc_pkg::SECT_GREEN: begin
                n1_a = r0_b;
                n1_b = r0_r;
            end
            default: begin
                n1_a = r0_r;
                n1_b = r0_g;
            end
        endcase
        n1_neg = n1_a < n1_b;
        n1_mag = n1_neg ? (n1_b - n1_a) : (n1_a - n1_b);
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_mx  <= n1_mx;
            r1_del <= n1_mx - n1_mn;
            r1_sec <= n1_sec;
            r1_neg <= n1_neg;
            r1_mag <= n1_mag;
        end
    end

    // stage 2: numerators, hue slope as two shifts
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_hrem[0] <= (RW'(r1_mag) << rhc_pkg::HUE_SLOPE_HI)
                       - (RW'(r1_mag) << rhc_pkg::HUE_SLOPE_LO);
            r_srem[0] <= RW'(r1_del) << rhc_pkg::SAT_FRAC;
            r_hq[0]   <= '0;
            r_sq[0]   <= '0;
            r_dmx[0]  <= r1_mx;
            r_ddel[0] <= r1_del;
            r_dsec[0] <= r1_sec;
            r_dneg[0] <= r1_neg;
        end
    end

    // divider stages: one restoring step of each divider per stage
    for (genvar j = 0; j < DQ; j++) begin : g_div
        localparam int SH = DQ - 1 - j;
        logic [RW-1:0] hdiv, sdiv;
        logic          htake, stake;

        always_comb begin
            hdiv  = RW'(r_ddel[j]) << SH;
            sdiv  = RW'(r_dmx[j]) << SH;
            htake = r_hrem[j] >= hdiv;
            stake = r_srem[j] >= sdiv;
        end

        always_ff @(posedge i_clk) begin
            if (ld[3+j]) begin
                r_hrem[j+1] <= htake ? (r_hrem[j] - hdiv) : r_hrem[j];
                r_srem[j+1] <= stake ? (r_srem[j] - sdiv) : r_srem[j];
                r_hq[j+1]   <= {r_hq[j][DQ-2:0], htake};
                r_sq[j+1]   <= {r_sq[j][DQ-2:0], stake};
                r_dmx[j+1]  <= r_dmx[j];
                r_ddel[j+1] <= r_ddel[j];
                r_dsec[j+1] <= r_dsec[j];
                r_dneg[j+1] <= r_dneg[j];
            end
        end
    end

    // output stage: sector base, sign, wrap and the black and grey cases
    logic [rhc_pkg::HUE_BITS-1:0] hbase, hq_ext, hval;
    logic [EW-1:0]                mx_ext;

    always_comb begin
        case (r_dsec[DQ])
            rhc_pkg::SECT_RED:   hbase = '0;
            rhc_pkg::SECT_GREEN: hbase = rhc_pkg::HUE_SECTOR;
            default:             hbase = rhc_pkg::HUE_SECTOR << 1;
        endcase
        hq_ext = rhc_pkg::HUE_BITS'(r_hq[DQ]);
        if (!r_dneg[DQ]) begin
            hval = hbase + hq_ext;
        end else if (hbase >= hq_ext) begin
            hval = hbase - hq_ext;
        end else begin
            hval = hbase + rhc_pkg::HUE_FULL - hq_ext;
        end
        mx_ext = EW'(r_dmx[DQ]);

        n_out.brightness    = mx_ext[rhc_pkg::BRIGHT_BITS-1:0];
        n_out.hue           = '0;
        n_out.saturation    = '0;
        n_out.hue_undefined = 1'b0;
        if (r_dmx[DQ] != '0) begin
            n_out.saturation = r_sq[DQ][rhc_pkg::SAT_BITS-1:0];
            if (r_ddel[DQ] == '0) begin
                n_out.hue_undefined = 1'b1;
            end else begin
                n_out.hue = hval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[NS-1]) begin
            r_out <= n_out;
        end
    end

    // checks on the datapath and the load chain
    `RHC_ASSERT(a_hue_range, o_valid |-> (o_hsv.hue < rhc_pkg::HUE_FULL))
    `RHC_ASSERT(a_sat_range, o_valid |-> (o_hsv.saturation <= 9'd256))
    `RHC_ASSERT(a_grey_zero,
        (o_valid && o_hsv.hue_undefined) |-> (o_hsv.hue == '0 && o_hsv.saturation == '0))
    `RHC_ASSERT(a_delta_le_max, r_v[1] |-> (r1_del <= r1_mx))
    `RHC_ASSERT(a_stall_full, o_stall |-> (r_v[0] && r_v[NS-1] && i_stall))
    `RHC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid)

endmodule

FILE: bench/tb_rgb_to_hsv_conversion.sv
// self-checking bench for the rgb to hsv converter with a scoreboard and random idling
module tb_rgb_to_hsv_conversion;

    localparam int unsigned HUE_SLOPE   = 3840;
    localparam int unsigned SAT_ONE     = 256;
    localparam int          HOLD_CYCLES = 60;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 24;

    // keeps predicted hsv beats in input order and checks results against them
    class hsv_scoreboard;
        rhc_pkg::t_hsv_pixel expected_q[$];
        int n_pixels;
        int n_checked;
        int n_errors;
        int n_grey;
        int n_black;

        // signed hue offset 3840*(a-b)/delta, truncated toward zero
        function int hue_offset(int unsigned a, int unsigned b, int unsigned delta);
            if (a >= b) begin
                return int'(((a - b) * HUE_SLOPE) / delta);
            end
            return -int'(((b - a) * HUE_SLOPE) / delta);
        endfunction

        function rhc_pkg::t_hsv_pixel predict_hsv(rhc_pkg::t_rgb_pixel px);
            rhc_pkg::t_hsv_pixel  res;
            int unsigned          r, g, b, mx, mn, delta;
            int                   h;
            rhc_pkg::t_hue_sector sect;
            r = 32'(px.red);
            g = 32'(px.green);
            b = 32'(px.blue);
            // strict compares give red priority over green, green over blue
            mx   = r;
            mn   = r;
            sect = rhc_pkg::SECT_RED;
            if (g > mx) begin
                mx   = g;
                sect = rhc_pkg::SECT_GREEN;
            end
            if (b > mx) begin
                mx   = b;
                sect = rhc_pkg::SECT_BLUE;
            end
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            delta = mx - mn;
            res = '0;
            res.brightness = mx[rhc_pkg::BRIGHT_BITS-1:0];
            if (mx != 0) begin
                res.saturation = rhc_pkg::SAT_BITS'((delta * SAT_ONE) / mx);
                if (delta == 0) begin
                    res.hue_undefined = 1'b1;
                end else begin
                    case (sect)
                        rhc_pkg::SECT_RED: begin
                            h = hue_offset(g, b, delta);
                        end
                        rhc_pkg::SECT_GREEN: begin
                            h = int'(rhc_pkg::HUE_SECTOR) + hue_offset(b, r, delta);
                        end
                        default: begin
                            h = 2 * int'(rhc_pkg::HUE_SECTOR) + hue_offset(r, g, delta);
                        end
                    endcase
                    // negative hue wraps by a full turn
                    if (h < 0) h += int'(rhc_pkg::HUE_FULL);
                    res.hue = rhc_pkg::HUE_BITS'(h);
                end
            end
            return res;
        endfunction

        function void note_pixel(rhc_pkg::t_rgb_pixel px);
            rhc_pkg::t_hsv_pixel want;
            want = predict_hsv(px);
            expected_q.push_back(want);
            n_pixels++;
            if (want.hue_undefined) n_grey++;
            if (want.brightness == 0) n_black++;
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("%0t: beat %0d %s mismatch, got %0d expected %0d",
                     $time, n_checked, what, got, want);
            n_errors++;
        endtask

        task check_result(rhc_pkg::t_hsv_pixel got);
            rhc_pkg::t_hsv_pixel want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", 32'(got.hue), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.hue !== want.hue)
                report_mismatch("hue", 32'(got.hue), 32'(want.hue));
            if (got.saturation !== want.saturation)
                report_mismatch("saturation", 32'(got.saturation), 32'(want.saturation));
            if (got.brightness !== want.brightness)
                report_mismatch("brightness", 32'(got.brightness), 32'(want.brightness));
            if (got.hue_undefined !== want.hue_undefined)
                report_mismatch("hue_undefined", 32'(got.hue_undefined),
                                32'(want.hue_undefined));
            n_checked++;
        endtask
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    rhc_pkg::t_rgb_pixel i_rgb   = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    rhc_pkg::t_hsv_pixel o_hsv;

    hsv_scoreboard sb;
    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    bit long_hold   = 1'b0;
    int quiet_cycles = 0;

    rgb_to_hsv_conversion u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_rgb   (i_rgb),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hsv   (o_hsv)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random pixel, biased toward greys, ties and the corners
    function automatic rhc_pkg::t_rgb_pixel gen_pixel();
        rhc_pkg::t_rgb_pixel px;
        logic [7:0]          v;
        px = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255))};
        v  = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: px = {v, v, v};
            1: px.green = px.red;
            2: px.blue = px.green;
            3: px.blue = px.red;
            4: px = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3))};
            5: begin
                px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            default: ;
        endcase
        return px;
    endfunction

    // offer one beat, with an optional idle burst ahead of it
    task automatic send_pixel(input rhc_pkg::t_rgb_pixel px);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rgb   <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver: random stall bursts and one long hold-off
    initial begin : sink
        int n;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // beat monitor, output side first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_hsv);
            if (i_valid && !o_stall) sb.note_pixel(i_rgb);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("tb_rgb_to_hsv_conversion: errors");
                $finish;
            end
        end
    end

    // stimulus
    initial begin : main
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;

        // black, white, greys and pure primaries
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd1, 8'd1, 8'd1});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd255});
        // ties for the maximum
        send_pixel({8'd255, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd255});
        send_pixel({8'd255, 8'd0, 8'd255});
        send_pixel({8'd128, 8'd128, 8'd127});
        send_pixel({8'd9, 8'd200, 8'd200});
        // negative offsets in each sector, red one wraps
        send_pixel({8'd255, 8'd0, 8'd10});
        send_pixel({8'd10, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd10, 8'd255});
        // smallest deltas and mid-range mixes
        send_pixel({8'd255, 8'd254, 8'd254});
        send_pixel({8'd1, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd1});
        send_pixel({8'd255, 8'd1, 8'd0});
        send_pixel({8'd0, 8'd1, 8'd255});
        send_pixel({8'd200, 8'd100, 8'd50});
        send_pixel({8'd50, 8'd100, 8'd200});
        send_pixel({8'haa, 8'h55, 8'h00});
        send_pixel({8'h55, 8'haa, 8'hff});

        // random pixels with idling on both sides
        repeat (300) send_pixel(gen_pixel());

        // receiver holds off while the sender keeps offering
        src_gaps  = 1'b0;
        long_hold = 1'b1;
        repeat (40) send_pixel(gen_pixel());

        // back to back, no idling
        sink_stalls = 1'b0;
        repeat (90) send_pixel(gen_pixel());
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d pixels and %0d checked results (%0d grey, %0d black),",
                 sb.n_pixels, sb.n_checked, sb.n_grey, sb.n_black);
        $display("with random idling, one long receiver hold-off and a back-to-back tail");
        if (sb.n_errors == 0) begin
            $display("tb_rgb_to_hsv_conversion: clean");
        end else begin
            $display("tb_rgb_to_hsv_conversion: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rgb_to_hsv_conversion.sv
bench/tb_rgb_to_hsv_conversion.sv
